/* rtl/gf_prime_polynomial_unit_macros.svh */
// assertion macros for the gf(prime) polynomial unit checker
// expects signals clk and rst_n in the scope of use
`ifndef GF_PRIME_POLYNOMIAL_UNIT_MACROS_SVH
`define GF_PRIME_POLYNOMIAL_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define GFP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define GFP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/gfp_pkg.sv */
// shared constants, item types and field arithmetic helpers
// no dependencies
package gfp_pkg;

  localparam int PRIME     = 929;
  localparam int MAX_TERMS = 32;

  localparam int CW  = 10;  // coefficient width
  localparam int FW  = 4;   // func width
  localparam int SDW = 5;   // shift degree width
  localparam int DGW = 6;   // term degree width
  localparam int STW = 2;   // status width

  localparam int AW  = $clog2(MAX_TERMS);        // poly / quotient address
  localparam int LW  = $clog2(MAX_TERMS + 1);    // poly length
  localparam int SAW = $clog2(2 * MAX_TERMS);    // scratch address
  localparam int KW  = $clog2(MAX_TERMS + 32);   // result length / position

  // reciprocal for reduction of products below 2^(2*CW)
  localparam int RED_S = 30;
  localparam longint unsigned RED_K = ((64'd1 << RED_S) + PRIME - 1) / PRIME;
  localparam int RKW = RED_S;

  // inverse by exponentiation to PRIME-2
  localparam int EW = $clog2(PRIME);
  localparam logic [EW-1:0] EXP_V = EW'(PRIME - 2);

  localparam logic [FW-1:0] F_LOAD_A = 4'd0;
  localparam logic [FW-1:0] F_LOAD_B = 4'd1;
  localparam logic [FW-1:0] F_EVAL   = 4'd2;
  localparam logic [FW-1:0] F_ADD    = 4'd3;
  localparam logic [FW-1:0] F_SUB    = 4'd4;
  localparam logic [FW-1:0] F_MUL    = 4'd5;
  localparam logic [FW-1:0] F_SCALE  = 4'd6;
  localparam logic [FW-1:0] F_MONO   = 4'd7;
  localparam logic [FW-1:0] F_DIV    = 4'd8;

  localparam logic [STW-1:0] ST_OK   = 2'd0;
  localparam logic [STW-1:0] ST_DIV0 = 2'd1;
  localparam logic [STW-1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [FW-1:0]  func;
    logic [CW-1:0]  coeff_value;
    logic           load_last;
    logic [CW-1:0]  factor;
    logic [SDW-1:0] shift_degree;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0]  out_coeff;
    logic [DGW-1:0] term_degree;
    logic           part;
    logic           last;
    logic [STW-1:0] status;
  } out_item_t;

  // reduce a raw field value mod PRIME
  function automatic logic [CW-1:0] mod_small(input logic [CW-1:0] x);
    logic [CW+RKW-1:0] pq;
    logic [CW-1:0]     q;
    logic [2*CW-1:0]   qp;
    pq = (CW+RKW)'(x) * (CW+RKW)'(RED_K);
    q  = pq[RED_S +: CW];
    qp = (2*CW)'(q) * (2*CW)'(PRIME);
    return CW'((2*CW)'(x) - qp);
  endfunction

  function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(PRIME)) s = s - (CW+1)'(PRIME);
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW+1:0] s;
    s = (CW+2)'(a) + (CW+2)'(PRIME) - (CW+2)'(b);
    if (s >= (CW+2)'(PRIME)) s = s - (CW+2)'(PRIME);
    return s[CW-1:0];
  endfunction

endpackage

/* rtl/gfp_channels.sv */
// valid/ready channel interfaces for input and result items
// depends on gfp_pkg
interface gfp_in_if;
  import gfp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gfp_out_if;
  import gfp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gfp_ram.sv */
// generic single-port-write, single-port-read ram, registered read data
// no dependencies
module gfp_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule

/* rtl/gfp_modmul.sv */
// two-stage modular multiplier: product, then quotient; result is held
// depends on gfp_pkg
module gfp_modmul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [gfp_pkg::CW-1:0] x,
  input  logic [gfp_pkg::CW-1:0] y,
  output logic [gfp_pkg::CW-1:0] result
);
  import gfp_pkg::*;

  logic              st1_r;
  logic [2*CW-1:0]   p_r;
  logic [2*CW-1:0]   p2_r;
  logic [CW-1:0]     q_r;
  logic [2*CW+RKW-1:0] pk;
  logic [2*CW-1:0]   qp;

  always_ff @(posedge clk) begin
    if (!rst_n) st1_r <= 1'b0;
    else        st1_r <= start;
  end

  always_ff @(posedge clk) begin
    if (start) p_r <= (2*CW)'(x) * (2*CW)'(y);
  end

  // quotient estimate by reciprocal, exact for products below PRIME*PRIME
  assign pk = (2*CW+RKW)'(p_r) * (2*CW+RKW)'(RED_K);

  always_ff @(posedge clk) begin
    if (st1_r) begin
      q_r  <= pk[RED_S +: CW];
      p2_r <= p_r;
    end
  end

  assign qp     = (2*CW)'(q_r) * (2*CW)'(PRIME);
  assign result = CW'(p2_r - qp);
endmodule

/* rtl/gf_prime_polynomial_unit.sv */
// top level: polynomial unit over gf(prime), sequencer around four rams
// depends on gfp_pkg, gfp_channels, gfp_ram, gfp_modmul
//
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   func, coeff_value, load_last, factor, shift_degree
//  out_ch    out   valid/ready   out_coeff, term_degree, part, last, status
//
// a load leaves the sequencer idle, an overflowing one first emits its error result; operations run one item
// at a time, ready is low while busy and while reset is held
// operation time is set by the shared modular multiplier; each multiply-accumulate steps through
// read, start, wait and accumulate, and a/b first copies the dividend and forms the inverse
// stalls on out_ch hold the sequencer
// reset is synchronous, no clearing pass: stored polynomials start as the zero polynomial
module gf_prime_polynomial_unit (
  input  logic      clk,
  input  logic      rst_n,
  gfp_in_if.sink    in_ch,
  gfp_out_if.source out_ch
);
  import gfp_pkg::*;

  // load tracking codes
  localparam logic [1:0] OPEN_NONE = 2'd0;
  localparam logic [1:0] OPEN_A    = 2'd1;
  localparam logic [1:0] OPEN_B    = 2'd2;

  // sequencer states
  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_ONE     = 6'd1;
  localparam logic [5:0] S_MW      = 6'd2;
  localparam logic [5:0] S_OFFER   = 6'd3;
  localparam logic [5:0] S_EV_LD   = 6'd4;
  localparam logic [5:0] S_EV_LOOP = 6'd5;
  localparam logic [5:0] S_EV_ACC  = 6'd6;
  localparam logic [5:0] S_AS_RD   = 6'd7;
  localparam logic [5:0] S_AS_EM   = 6'd8;
  localparam logic [5:0] S_SC_RD   = 6'd9;
  localparam logic [5:0] S_SC_MUL  = 6'd10;
  localparam logic [5:0] S_SC_GET  = 6'd11;
  localparam logic [5:0] S_MU_INIT = 6'd12;
  localparam logic [5:0] S_MU_RD   = 6'd13;
  localparam logic [5:0] S_MU_MUL  = 6'd14;
  localparam logic [5:0] S_MU_ACC  = 6'd15;
  localparam logic [5:0] S_DV_CPR  = 6'd16;
  localparam logic [5:0] S_DV_CPW  = 6'd17;
  localparam logic [5:0] S_DV_INV0 = 6'd18;
  localparam logic [5:0] S_DV_INV1 = 6'd19;
  localparam logic [5:0] S_DV_INVA = 6'd20;
  localparam logic [5:0] S_DV_INV2 = 6'd21;
  localparam logic [5:0] S_DV_INVB = 6'd22;
  localparam logic [5:0] S_DV_QRD  = 6'd23;
  localparam logic [5:0] S_DV_QMUL = 6'd24;
  localparam logic [5:0] S_DV_QW   = 6'd25;
  localparam logic [5:0] S_DV_JRD  = 6'd26;
  localparam logic [5:0] S_DV_JMUL = 6'd27;
  localparam logic [5:0] S_DV_JW   = 6'd28;
  localparam logic [5:0] S_DV_QPH  = 6'd29;
  localparam logic [5:0] S_DV_RPH  = 6'd30;
  localparam logic [5:0] S_EM_RD   = 6'd31;
  localparam logic [5:0] S_EM_GET  = 6'd32;

  // control registers
  logic [5:0]  state_r, state_nxt, ret_r, ret_nxt, loop_r, loop_nxt, post_r, post_nxt;
  logic [1:0]  open_r, open_nxt;
  logic [LW-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic [LW-1:0] lz_a_r, lz_a_nxt, lz_b_r, lz_b_nxt;   // leading zero count as loaded
  logic        out_valid_r, out_valid_nxt;

  // working registers
  logic [KW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, len_r, len_nxt, iend_r, iend_nxt;
  logic [SAW-1:0] ebase_r, ebase_nxt;
  logic        lead_r, lead_nxt, part_r, part_nxt, final_r, final_nxt;
  logic        aok_r, aok_nxt, bok_r, bok_nxt, emq_r, emq_nxt;
  logic [CW-1:0] val_r, val_nxt, acc_r, acc_nxt, fac_r, fac_nxt;
  logic [CW-1:0] inv_r, inv_nxt, base_r, base_nxt, q_r, q_nxt;
  logic [EW-1:0] exp_r, exp_nxt;
  logic [STW-1:0] st_r, st_nxt;
  logic [FW-1:0]  func_r, func_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // ram ports
  logic          a_we, a_re, b_we, b_re, s_we, s_re, q_we, q_re;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr, q_waddr, q_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [CW-1:0] a_wdata, b_wdata, s_wdata, q_wdata, a_q, b_q, s_q, q_q;
  logic [CW-1:0] a_dat, b_dat;

  // multiplier
  logic          mul_start;
  logic [CW-1:0] mul_x, mul_y, m_res;

  // derived
  logic          in_fire, a_allz, b_allz, na_ge;
  logic [LW-1:0] sa, sb, na, nb;
  logic [KW-1:0] sa_k, sb_k, na_k, nb_k, nq_k, ao_a, ao_b;
  logic [CW-1:0] cv_red, fac_red;
  logic          ld_sel_b, ld_restart, ld_room;
  logic [LW-1:0] ld_len, ld_lz, ld_lz_new;
  logic          last_pos, skip, can_push;

  gfp_ram #(.DEPTH(MAX_TERMS), .WIDTH(CW)) u_ram_a (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_q)
  );
  gfp_ram #(.DEPTH(MAX_TERMS), .WIDTH(CW)) u_ram_b (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_q)
  );
  gfp_ram #(.DEPTH(2*MAX_TERMS), .WIDTH(CW)) u_ram_scr (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_q)
  );
  gfp_ram #(.DEPTH(MAX_TERMS), .WIDTH(CW)) u_ram_quo (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_q)
  );

  gfp_modmul u_modmul (
    .clk, .rst_n, .start(mul_start), .x(mul_x), .y(mul_y), .result(m_res)
  );

  // no item is taken while reset is held
  assign in_ch.ready  = (state_r == S_IDLE) && rst_n;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // normalized views of the stored polynomials; an all-zero poly reads as zeros
  assign a_allz = (lz_a_r == len_a_r);
  assign b_allz = (lz_b_r == len_b_r);
  assign sa     = a_allz ? len_a_r - LW'(1) : lz_a_r;
  assign sb     = b_allz ? len_b_r - LW'(1) : lz_b_r;
  assign na     = len_a_r - sa;
  assign nb     = len_b_r - sb;
  assign sa_k   = KW'(sa);
  assign sb_k   = KW'(sb);
  assign na_k   = KW'(na);
  assign nb_k   = KW'(nb);
  assign na_ge  = (na >= nb);
  assign nq_k   = na_k - nb_k + KW'(1);
  assign ao_a   = len_r - na_k;
  assign ao_b   = len_r - nb_k;
  assign a_dat  = a_allz ? '0 : a_q;
  assign b_dat  = b_allz ? '0 : b_q;

  assign cv_red  = mod_small(in_ch.data.coeff_value);
  assign fac_red = mod_small(in_ch.data.factor);

  // load bookkeeping for the polynomial named by the item
  assign ld_sel_b   = (in_ch.data.func == F_LOAD_B);
  assign ld_restart = (open_r != (ld_sel_b ? OPEN_B : OPEN_A));
  assign ld_len     = ld_restart ? '0 : (ld_sel_b ? len_b_r : len_a_r);
  assign ld_lz      = ld_restart ? '0 : (ld_sel_b ? lz_b_r : lz_a_r);
  assign ld_room    = (ld_len < LW'(MAX_TERMS));
  assign ld_lz_new  = (ld_lz == ld_len && cv_red == '0) ? ld_lz + LW'(1) : ld_lz;

  // result emitter: strips leading zeros, never the final position
  assign last_pos = (k_r == len_r - KW'(1));
  assign skip     = lead_r && (val_r == '0) && !last_pos;
  assign can_push = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  loop_nxt = loop_r;  post_nxt = post_r;
    open_nxt = open_r;
    len_a_nxt = len_a_r;  len_b_nxt = len_b_r;  lz_a_nxt = lz_a_r;  lz_b_nxt = lz_b_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;  len_nxt = len_r;  iend_nxt = iend_r;
    ebase_nxt = ebase_r;  lead_nxt = lead_r;  part_nxt = part_r;  final_nxt = final_r;
    aok_nxt = aok_r;  bok_nxt = bok_r;  emq_nxt = emq_r;
    val_nxt = val_r;  acc_nxt = acc_r;  fac_nxt = fac_r;  inv_nxt = inv_r;
    base_nxt = base_r;  q_nxt = q_r;  exp_nxt = exp_r;  st_nxt = st_r;
    func_nxt = func_r;
    a_we = 1'b0;  a_waddr = '0;  a_wdata = '0;  a_re = 1'b0;  a_raddr = '0;
    b_we = 1'b0;  b_waddr = '0;  b_wdata = '0;  b_re = 1'b0;  b_raddr = '0;
    s_we = 1'b0;  s_waddr = '0;  s_wdata = '0;  s_re = 1'b0;  s_raddr = '0;
    q_we = 1'b0;  q_waddr = '0;  q_wdata = '0;  q_re = 1'b0;  q_raddr = '0;
    mul_start = 1'b0;  mul_x = '0;  mul_y = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.func == F_LOAD_A || in_ch.data.func == F_LOAD_B) begin
            if (ld_room) begin
              if (ld_sel_b) begin
                b_we = 1'b1;  b_waddr = AW'(ld_len);  b_wdata = cv_red;
                len_b_nxt = ld_len + LW'(1);  lz_b_nxt = ld_lz_new;
              end else begin
                a_we = 1'b1;  a_waddr = AW'(ld_len);  a_wdata = cv_red;
                len_a_nxt = ld_len + LW'(1);  lz_a_nxt = ld_lz_new;
              end
            end else begin
              // coefficient past capacity is dropped, load stays open unless the item is the last
              val_nxt = '0;  st_nxt = ST_OVF;  state_nxt = S_ONE;
            end
            open_nxt = in_ch.data.load_last ? OPEN_NONE : (ld_sel_b ? OPEN_B : OPEN_A);
          end else if (in_ch.data.func <= F_DIV) begin
            open_nxt = OPEN_NONE;
            func_nxt = in_ch.data.func;
            fac_nxt  = fac_red;
            // emitter defaults: main part, final run
            k_nxt = '0;  lead_nxt = 1'b1;  part_nxt = 1'b0;  final_nxt = 1'b1;
            post_nxt = S_IDLE;  loop_nxt = S_IDLE;
            priority case (in_ch.data.func)
              F_EVAL: begin
                a_re = 1'b1;  a_raddr = AW'(sa);
                state_nxt = S_EV_LD;
              end
              F_ADD, F_SUB: begin
                len_nxt = na_ge ? na_k : nb_k;
                loop_nxt = S_AS_RD;  state_nxt = S_AS_RD;
              end
              F_MUL: begin
                len_nxt = na_k + nb_k - KW'(1);
                loop_nxt = S_MU_INIT;  state_nxt = S_MU_INIT;
              end
              F_SCALE, F_MONO: begin
                if (in_ch.data.func == F_MONO && fac_red == '0) begin
                  // zero monomial coefficient gives the zero polynomial
                  len_nxt = KW'(1);  val_nxt = '0;  state_nxt = S_OFFER;
                end else begin
                  len_nxt = (in_ch.data.func == F_MONO)
                            ? na_k + KW'(in_ch.data.shift_degree) : na_k;
                  loop_nxt = S_SC_RD;  state_nxt = S_SC_RD;
                end
              end
              default: begin
                if (b_allz) begin
                  val_nxt = '0;  st_nxt = ST_DIV0;  state_nxt = S_ONE;
                end else begin
                  i_nxt = '0;  state_nxt = S_DV_CPR;
                end
              end
            endcase
          end
        end
      end

      // single result: evaluation value or an error
      S_ONE: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_coeff: val_r, term_degree: '0, part: 1'b0,
                            last: 1'b1, status: st_r};
          st_nxt    = ST_OK;
          state_nxt = S_IDLE;
        end
      end

      // wait for the multiplier, then continue
      S_MW: state_nxt = ret_r;

      S_OFFER: begin
        if (skip || can_push) begin
          if (!skip) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{out_coeff: val_r, term_degree: DGW'(len_r - KW'(1) - k_r),
                              part: part_r, last: final_r && last_pos, status: ST_OK};
            lead_nxt = 1'b0;
          end
          k_nxt     = k_r + KW'(1);
          state_nxt = last_pos ? post_r : loop_r;
        end
      end

      // horner evaluation
      S_EV_LD: begin
        acc_nxt = a_dat;  i_nxt = KW'(1);  state_nxt = S_EV_LOOP;
      end
      S_EV_LOOP: begin
        if (i_r == na_k) begin
          val_nxt = acc_r;  st_nxt = ST_OK;  state_nxt = S_ONE;
        end else begin
          mul_start = 1'b1;  mul_x = fac_r;  mul_y = acc_r;
          a_re = 1'b1;  a_raddr = AW'(sa_k + i_r);
          ret_nxt = S_EV_ACC;  state_nxt = S_MW;
        end
      end
      S_EV_ACC: begin
        acc_nxt = add_mod(m_res, a_dat);  i_nxt = i_r + KW'(1);  state_nxt = S_EV_LOOP;
      end

      // sum and difference, aligned at the low end
      S_AS_RD: begin
        aok_nxt = (k_r >= ao_a);
        bok_nxt = (k_r >= ao_b);
        a_re = 1'b1;  a_raddr = AW'(sa_k + k_r - ao_a);
        b_re = 1'b1;  b_raddr = AW'(sb_k + k_r - ao_b);
        state_nxt = S_AS_EM;
      end
      S_AS_EM: begin
        val_nxt = (func_r == F_ADD)
                  ? add_mod(aok_r ? a_dat : '0, bok_r ? b_dat : '0)
                  : sub_mod(aok_r ? a_dat : '0, bok_r ? b_dat : '0);
        state_nxt = S_OFFER;
      end

      // scale and monomial product
      S_SC_RD: begin
        if (k_r < na_k) begin
          a_re = 1'b1;  a_raddr = AW'(sa_k + k_r);  state_nxt = S_SC_MUL;
        end else begin
          val_nxt = '0;  state_nxt = S_OFFER;
        end
      end
      S_SC_MUL: begin
        mul_start = 1'b1;  mul_x = a_dat;  mul_y = fac_r;
        ret_nxt = S_SC_GET;  state_nxt = S_MW;
      end
      S_SC_GET: begin
        val_nxt = m_res;  state_nxt = S_OFFER;
      end

      // product: one output coefficient at a time, sum over i + j == k
      S_MU_INIT: begin
        acc_nxt  = '0;
        i_nxt    = (k_r >= nb_k) ? k_r - nb_k + KW'(1) : '0;
        iend_nxt = (k_r < na_k) ? k_r : na_k - KW'(1);
        state_nxt = S_MU_RD;
      end
      S_MU_RD: begin
        a_re = 1'b1;  a_raddr = AW'(sa_k + i_r);
        b_re = 1'b1;  b_raddr = AW'(sb_k + k_r - i_r);
        state_nxt = S_MU_MUL;
      end
      S_MU_MUL: begin
        mul_start = 1'b1;  mul_x = a_dat;  mul_y = b_dat;
        ret_nxt = S_MU_ACC;  state_nxt = S_MW;
      end
      S_MU_ACC: begin
        acc_nxt = add_mod(acc_r, m_res);
        if (i_r == iend_r) begin
          val_nxt = add_mod(acc_r, m_res);  state_nxt = S_OFFER;
        end else begin
          i_nxt = i_r + KW'(1);  state_nxt = S_MU_RD;
        end
      end

      // division: copy dividend into scratch
      S_DV_CPR: begin
        a_re = 1'b1;  a_raddr = AW'(sa_k + i_r);  state_nxt = S_DV_CPW;
      end
      S_DV_CPW: begin
        s_we = 1'b1;  s_waddr = SAW'(i_r);  s_wdata = a_dat;
        if (i_r == na_k - KW'(1)) begin
          if (na_ge) begin
            b_re = 1'b1;  b_raddr = AW'(sb);  state_nxt = S_DV_INV0;
          end else begin
            state_nxt = S_DV_QPH;
          end
        end else begin
          i_nxt = i_r + KW'(1);  state_nxt = S_DV_CPR;
        end
      end

      // inverse of the leading divisor coefficient by square and multiply
      S_DV_INV0: begin
        base_nxt = b_dat;  inv_nxt = CW'(1);  exp_nxt = EXP_V;  state_nxt = S_DV_INV1;
      end
      S_DV_INV1: begin
        if (exp_r == '0) begin
          i_nxt = '0;  state_nxt = S_DV_QRD;
        end else if (exp_r[0]) begin
          mul_start = 1'b1;  mul_x = inv_r;  mul_y = base_r;
          ret_nxt = S_DV_INVA;  state_nxt = S_MW;
        end else begin
          state_nxt = S_DV_INV2;
        end
      end
      S_DV_INVA: begin
        inv_nxt = m_res;  state_nxt = S_DV_INV2;
      end
      S_DV_INV2: begin
        mul_start = 1'b1;  mul_x = base_r;  mul_y = base_r;
        ret_nxt = S_DV_INVB;  state_nxt = S_MW;
      end
      S_DV_INVB: begin
        base_nxt = m_res;  exp_nxt = exp_r >> 1;  state_nxt = S_DV_INV1;
      end

      // long division, read-modify-write on scratch one entry at a time
      S_DV_QRD: begin
        s_re = 1'b1;  s_raddr = SAW'(i_r);  state_nxt = S_DV_QMUL;
      end
      S_DV_QMUL: begin
        mul_start = 1'b1;  mul_x = s_q;  mul_y = inv_r;
        ret_nxt = S_DV_QW;  state_nxt = S_MW;
      end
      S_DV_QW: begin
        q_nxt = m_res;
        q_we = 1'b1;  q_waddr = AW'(i_r);  q_wdata = m_res;
        j_nxt = '0;  state_nxt = S_DV_JRD;
      end
      S_DV_JRD: begin
        s_re = 1'b1;  s_raddr = SAW'(i_r + j_r);
        b_re = 1'b1;  b_raddr = AW'(sb_k + j_r);
        state_nxt = S_DV_JMUL;
      end
      S_DV_JMUL: begin
        mul_start = 1'b1;  mul_x = q_r;  mul_y = b_dat;
        ret_nxt = S_DV_JW;  state_nxt = S_MW;
      end
      S_DV_JW: begin
        s_we = 1'b1;  s_waddr = SAW'(i_r + j_r);  s_wdata = sub_mod(s_q, m_res);
        if (j_r == nb_k - KW'(1)) begin
          if (i_r == nq_k - KW'(1)) begin
            state_nxt = S_DV_QPH;
          end else begin
            i_nxt = i_r + KW'(1);  state_nxt = S_DV_QRD;
          end
        end else begin
          j_nxt = j_r + KW'(1);  state_nxt = S_DV_JRD;
        end
      end

      // quotient run, then remainder run
      S_DV_QPH: begin
        k_nxt = '0;  lead_nxt = 1'b1;  part_nxt = 1'b0;  final_nxt = 1'b0;
        post_nxt = S_DV_RPH;
        if (!na_ge) begin
          len_nxt = KW'(1);  val_nxt = '0;  state_nxt = S_OFFER;
        end else begin
          len_nxt = nq_k;  emq_nxt = 1'b1;  ebase_nxt = '0;
          loop_nxt = S_EM_RD;  state_nxt = S_EM_RD;
        end
      end
      S_DV_RPH: begin
        k_nxt = '0;  lead_nxt = 1'b1;  part_nxt = 1'b1;  final_nxt = 1'b1;
        post_nxt = S_IDLE;
        if (na_ge && nb_k == KW'(1)) begin
          len_nxt = KW'(1);  val_nxt = '0;  state_nxt = S_OFFER;
        end else begin
          len_nxt   = na_ge ? nb_k - KW'(1) : na_k;
          ebase_nxt = na_ge ? SAW'(nq_k) : '0;
          emq_nxt   = 1'b0;
          loop_nxt  = S_EM_RD;  state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        if (emq_r) begin
          q_re = 1'b1;  q_raddr = AW'(k_r);
        end else begin
          s_re = 1'b1;  s_raddr = ebase_r + SAW'(k_r);
        end
        state_nxt = S_EM_GET;
      end
      S_EM_GET: begin
        val_nxt = emq_r ? q_q : s_q;  state_nxt = S_OFFER;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= OPEN_NONE;
      len_a_r     <= LW'(1);
      len_b_r     <= LW'(1);
      lz_a_r      <= LW'(1);
      lz_b_r      <= LW'(1);
      out_valid_r <= 1'b0;
      st_r        <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      lz_a_r      <= lz_a_nxt;
      lz_b_r      <= lz_b_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  loop_r <= loop_nxt;  post_r <= post_nxt;
    i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;  len_r <= len_nxt;  iend_r <= iend_nxt;
    ebase_r <= ebase_nxt;  lead_r <= lead_nxt;  part_r <= part_nxt;  final_r <= final_nxt;
    aok_r <= aok_nxt;  bok_r <= bok_nxt;  emq_r <= emq_nxt;
    val_r <= val_nxt;  acc_r <= acc_nxt;  fac_r <= fac_nxt;  inv_r <= inv_nxt;
    base_r <= base_nxt;  q_r <= q_nxt;  exp_r <= exp_nxt;
    func_r <= func_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule

/* rtl/gfp_checker.sv */
// port-level checks for the gf(prime) polynomial unit, bound to the top level
// depends on gfp_pkg and gf_prime_polynomial_unit_macros.svh
`include "gf_prime_polynomial_unit_macros.svh"

module gfp_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [gfp_pkg::FW-1:0]  in_func,
  input logic                    out_valid,
  input logic                    out_ready,
  input gfp_pkg::out_item_t      out_data
);
  import gfp_pkg::*;

  `GFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  `GFP_ASSERT_NOW(a_err_shape, out_valid && out_data.status != ST_OK, out_data.last && out_data.out_coeff == '0 && out_data.term_degree == '0 && !out_data.part, "error item is not a lone zero item")

  `GFP_ASSERT_NOW(a_coeff_range, out_valid, out_data.out_coeff < CW'(PRIME), "coefficient not reduced")

  `GFP_ASSERT_NEXT(a_op_busy, in_valid && in_ready && in_func >= F_EVAL && in_func <= F_DIV, !in_ready, "took an item right after an operation")
endmodule

bind gf_prime_polynomial_unit gfp_checker u_gfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.data.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* dv/tb_gf_prime_polynomial_unit.sv */
// testbench for gf_prime_polynomial_unit: directed and random load/operation items
// with an in-bench polynomial predictor over gf(929); depends on gfp_pkg, gfp_channels
`timescale 1ns / 100ps

module tb_gf_prime_polynomial_unit;
  import gfp_pkg::*;

  // a func code with no operation behind it
  localparam logic [FW-1:0] F_UNUSED = 4'd15;

  class poly_scoreboard;
    int        poly[2][MAX_TERMS];
    int        plen[2];
    int        open_sel;  // 0 none, 1 loading a, 2 loading b
    out_item_t exp_q[$];
    int        errors;

    function new();
      for (int i = 0; i < MAX_TERMS; i++) begin
        poly[0][i] = 0;
        poly[1][i] = 0;
      end
      plen[0] = 1;
      plen[1] = 1;
      open_sel = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void push(int c, int deg, bit part, bit last, logic [STW-1:0] st);
      out_item_t e;
      e.out_coeff = CW'(c);
      e.term_degree = DGW'(deg);
      e.part = part;
      e.last = last;
      e.status = st;
      exp_q.push_back(e);
    endfunction

    // strip leading zeros, push highest degree first
    function void emit_poly(int src[2*MAX_TERMS], int off, int n, bit part, bit fin);
      int s;
      s = 0;
      while (s + 1 < n && src[off + s] == 0) s++;
      for (int i = 0; i < n - s; i++)
        push(src[off + s + i], n - s - 1 - i, part, fin && (i == n - s - 1), ST_OK);
    endfunction

    function int field_inv(int x);
      int r, b, e;
      r = 1;
      b = x;
      e = PRIME - 2;
      while (e != 0) begin
        if (e & 1) r = (r * b) % PRIME;
        b = (b * b) % PRIME;
        e = e >> 1;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      int f, cv, fac, sd, sel, na, nb, s, ln, inv, q, nq, rs, rl;
      int av[MAX_TERMS];
      int bv[MAX_TERMS];
      int wk[2*MAX_TERMS];
      int qs[2*MAX_TERMS];
      f = it.func;
      cv = it.coeff_value % PRIME;
      fac = it.factor % PRIME;
      sd = it.shift_degree;
      if (f == F_LOAD_A || f == F_LOAD_B) begin
        sel = (f == F_LOAD_B);
        // starting a new load or switching polynomial restarts its load
        if (open_sel != sel + 1) begin
          plen[sel] = 0;
          open_sel = sel + 1;
        end
        if (plen[sel] < MAX_TERMS) begin
          poly[sel][plen[sel]] = cv;
          plen[sel]++;
        end else push(0, 0, 0, 1, ST_OVF);
        if (it.load_last) open_sel = 0;
        return;
      end
      if (f > F_DIV) return;
      open_sel = 0;
      // normalized copies of a and b
      s = 0;
      while (s + 1 < plen[0] && poly[0][s] == 0) s++;
      na = plen[0] - s;
      for (int i = 0; i < na; i++) av[i] = poly[0][s + i];
      s = 0;
      while (s + 1 < plen[1] && poly[1][s] == 0) s++;
      nb = plen[1] - s;
      for (int i = 0; i < nb; i++) bv[i] = poly[1][s + i];
      for (int i = 0; i < 2*MAX_TERMS; i++) begin
        wk[i] = 0;
        qs[i] = 0;
      end
      case (f)
        F_EVAL: begin
          q = av[0];
          for (int i = 1; i < na; i++) q = (fac * q + av[i]) % PRIME;
          push(q, 0, 0, 1, ST_OK);
        end
        F_ADD, F_SUB: begin
          ln = (na > nb) ? na : nb;
          for (int i = 0; i < ln; i++) begin
            int d, ca, cb;
            d = ln - 1 - i;
            ca = (d < na) ? av[na - 1 - d] : 0;
            cb = (d < nb) ? bv[nb - 1 - d] : 0;
            wk[i] = (f == F_ADD) ? (ca + cb) % PRIME : (ca + PRIME - cb) % PRIME;
          end
          emit_poly(wk, 0, ln, 0, 1);
        end
        F_MUL: begin
          for (int i = 0; i < na; i++)
            for (int j = 0; j < nb; j++)
              wk[i + j] = (wk[i + j] + av[i] * bv[j]) % PRIME;
          emit_poly(wk, 0, na + nb - 1, 0, 1);
        end
        F_SCALE: begin
          for (int i = 0; i < na; i++) wk[i] = (av[i] * fac) % PRIME;
          emit_poly(wk, 0, na, 0, 1);
        end
        F_MONO: begin
          // zero coefficient collapses to the zero polynomial
          if (fac == 0) emit_poly(wk, 0, 1, 0, 1);
          else begin
            for (int i = 0; i < na; i++) wk[i] = (av[i] * fac) % PRIME;
            emit_poly(wk, 0, na + sd, 0, 1);
          end
        end
        default: begin
          if (nb == 1 && bv[0] == 0) begin
            push(0, 0, 0, 1, ST_DIV0);
            return;
          end
          for (int i = 0; i < na; i++) wk[i] = av[i];
          if (na >= nb) begin
            inv = field_inv(bv[0]);
            nq = na - nb + 1;
            for (int i = 0; i < nq; i++) begin
              q = (wk[i] * inv) % PRIME;
              qs[i] = q;
              for (int j = 0; j < nb; j++)
                wk[i + j] = (wk[i + j] + PRIME - (q * bv[j]) % PRIME) % PRIME;
            end
            rs = nq;
            rl = nb - 1;
            if (rl == 0) begin
              wk[0] = 0;
              rs = 0;
              rl = 1;
            end
          end else begin
            // degree of a below degree of b: quotient zero, remainder a
            nq = 1;
            rs = 0;
            rl = na;
          end
          emit_poly(qs, 0, nq, 0, 0);
          emit_poly(wk, rs, rl, 1, 1);
        end
      endcase
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (exp_q.size() == 0) begin
        report($sformatf("result with nothing pending: %p", got));
        return;
      end
      e = exp_q.pop_front();
      if (got.out_coeff !== e.out_coeff)
        report($sformatf("out_coeff %0d, want %0d", got.out_coeff, e.out_coeff));
      if (got.term_degree !== e.term_degree)
        report($sformatf("term_degree %0d, want %0d", got.term_degree, e.term_degree));
      if (got.part !== e.part)
        report($sformatf("part %0b, want %0b", got.part, e.part));
      if (got.last !== e.last)
        report($sformatf("last %0b, want %0b", got.last, e.last));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  gfp_in_if  in_ch();
  gfp_out_if out_ch();

  gf_prime_polynomial_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  poly_scoreboard sb = new();
  int  work_items;   // accepted items that do something
  int  hold_cycles;  // receiver back-pressure request
  bit  calm;         // no idling on either side
  bit  drained_mid;  // mid-run pause until all results are back
  bit  held_once;    // long receiver hold-off already done

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // results are checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else out_ch.ready = calm || ($urandom_range(99) >= 31);
    end
  end

  function automatic in_item_t mk(logic [FW-1:0] f, int cv, bit ll, int fac, int sd);
    in_item_t it;
    it.func = f;
    it.coeff_value = CW'(cv);
    it.load_last = ll;
    it.factor = CW'(fac);
    it.shift_degree = SDW'(sd);
    return it;
  endfunction

  // one item, held until accepted; each falling edge sees at most one assignment to valid
  task send(in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    if (it.func <= F_DIV) work_items++;
  endtask

  task drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
  endtask

  function automatic int rnd_coeff();
    if ($urandom_range(9) == 0) return $urandom_range(1023, 929);  // unreduced
    if ($urandom_range(5) == 0) return 0;
    return $urandom_range(928);
  endfunction

  // whole load of n coefficients, optionally leading zeros, optionally left open
  task load_poly(logic [FW-1:0] f, int n, bit lead0, bit leave_open);
    for (int k = 0; k < n; k++)
      send(mk(f, (lead0 && k == 0) ? 0 : rnd_coeff(), (k == n - 1) && !leave_open,
              $urandom_range(1023), $urandom_range(31)));
  endtask

  function automatic int rnd_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 20);
    if (r < 97) return $urandom_range(21, 32);
    return $urandom_range(33, 35);  // overflow
  endfunction

  initial begin
    int fsel;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    hold_cycles = 0;
    calm = 1'b0;
    drained_mid = 1'b0;
    held_once = 1'b0;
    work_items = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every operation, the corner cases
    send(mk(F_EVAL, 0, 0, 5, 0));                // zero polynomial after reset
    send(mk(F_LOAD_A, 928, 0, 0, 0));
    send(mk(F_LOAD_A, 1023, 0, 0, 0));           // reduced on load
    send(mk(F_LOAD_A, 0, 1, 0, 0));
    send(mk(F_LOAD_B, 1, 0, 0, 0));
    send(mk(F_LOAD_B, 928, 1, 0, 0));
    send(mk(F_EVAL, 0, 0, 1023, 0));
    send(mk(F_ADD, 0, 0, 0, 0));
    send(mk(F_SUB, 0, 0, 0, 0));
    send(mk(F_MUL, 0, 0, 0, 0));
    send(mk(F_SCALE, 0, 0, 0, 0));
    send(mk(F_MONO, 0, 0, 929, 31));             // zero monomial coefficient
    send(mk(F_MONO, 0, 0, 928, 31));
    send(mk(F_DIV, 0, 0, 0, 0));
    send(mk(F_LOAD_B, 0, 1, 0, 0));
    send(mk(F_DIV, 0, 0, 0, 0));                 // divide by zero
    send(mk(F_UNUSED, 1023, 1, 1023, 31));       // unused code, ignored
    send(mk(F_LOAD_A, 0, 0, 0, 0));              // leading zeros kept in storage
    send(mk(F_LOAD_A, 7, 1, 0, 0));
    send(mk(F_LOAD_B, 3, 0, 0, 0));
    send(mk(F_LOAD_B, 0, 0, 0, 0));
    send(mk(F_LOAD_B, 1, 1, 0, 0));
    send(mk(F_DIV, 0, 0, 0, 0));                 // deg a below deg b
    send(mk(F_LOAD_A, 5, 0, 0, 0));              // load left open
    send(mk(F_EVAL, 0, 0, 2, 0));
    drain();

    // random: load sequences with operations on them, some noise
    while (work_items < 230) begin
      if (work_items >= 80 && !drained_mid) begin
        drain();
        drained_mid = 1'b1;
      end
      if (work_items >= 120 && !held_once && !calm) begin
        hold_cycles = 3000;  // receiver holds off while items keep coming
        held_once = 1'b1;
      end
      calm = (work_items >= 170 && work_items < 215);
      if ($urandom_range(9) < 6)
        load_poly(F_LOAD_A, rnd_len(), $urandom_range(3) == 0, $urandom_range(9) == 0);
      if ($urandom_range(9) < 5) begin
        if ($urandom_range(7) == 0) send(mk(F_LOAD_B, 0, 1, 0, 0));
        else load_poly(F_LOAD_B, rnd_len(), $urandom_range(3) == 0,
                       $urandom_range(9) == 0);
      end
      repeat ($urandom_range(1, 3)) begin
        fsel = $urandom_range(F_EVAL, F_DIV);
        send(mk(FW'(fsel), $urandom_range(1023), 1'($urandom_range(1)),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(1023), $urandom_range(31)));
      end
      if ($urandom_range(9) == 0)
        send(mk(FW'($urandom_range(F_UNUSED, F_DIV + 1)), $urandom_range(1023),
                1'($urandom_range(1)), $urandom_range(1023), $urandom_range(31)));
    end
    calm = 1'b0;
    drain();
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.exp_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
